// File: sv/pft_pkg.sv
// Package for the threshold pulse finder: field widths, register map codes
// and the configuration struct shared by the register block and the top level.
// No dependencies.
package pft_pkg;

  // Waveform length limit and significant sample bits.
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 12;

  // Field widths of the item ports.
  localparam int SAMPLE_W  = 12;
  localparam int IDX_W     = 12;
  localparam int CHAN_W    = 10;
  localparam int AMP_W     = 17;
  localparam int AREA_W    = 28;
  localparam int LEVEL_W   = 16;
  localparam int SIGMA_W   = 12;
  localparam int SIGMAS_W  = 8;

  // Configuration port widths.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register indexes, one word apart on the configuration port.
  typedef enum logic [2:0] {
    REG_RISE_SIGMAS    = 3'd0,
    REG_FALL_SIGMAS    = 3'd1,
    REG_THRESHOLD      = 3'd2,
    REG_PEDESTAL_MEAN  = 3'd3,
    REG_PEDESTAL_SIGMA = 3'd4,
    REG_CHANNEL_ID     = 3'd5
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic [SIGMAS_W-1:0] RISE_SIGMAS_RST    = 8'd48;
  localparam logic [SIGMAS_W-1:0] FALL_SIGMAS_RST    = 8'd16;
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RST      = 16'd160;
  localparam logic [LEVEL_W-1:0]  PEDESTAL_MEAN_RST  = 16'd0;
  localparam logic [SIGMA_W-1:0]  PEDESTAL_SIGMA_RST = 12'd16;
  localparam logic [CHAN_W-1:0]   CHANNEL_ID_RST     = 10'd0;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [SIGMAS_W-1:0] rise_sigmas;
    logic [SIGMAS_W-1:0] fall_sigmas;
    logic [LEVEL_W-1:0]  threshold;
    logic [LEVEL_W-1:0]  pedestal_mean;
    logic [SIGMA_W-1:0]  pedestal_sigma;
    logic [CHAN_W-1:0]   channel_id;
  } cfg_t;

endpackage

// File: sv/pft_regs.sv
// Configuration register block of the threshold pulse finder: APB-style
// write and read access to the six settings. Depends on pft_pkg.
module pft_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pft_pkg::PADDR_W-1:0]  paddr,
  input  logic [pft_pkg::PDATA_W-1:0]  pwdata,
  output logic [pft_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output pft_pkg::cfg_t                cfg
);
  import pft_pkg::*;

  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_sigmas    <= RISE_SIGMAS_RST;
      cfg.fall_sigmas    <= FALL_SIGMAS_RST;
      cfg.threshold      <= THRESHOLD_RST;
      cfg.pedestal_mean  <= PEDESTAL_MEAN_RST;
      cfg.pedestal_sigma <= PEDESTAL_SIGMA_RST;
      cfg.channel_id     <= CHANNEL_ID_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RISE_SIGMAS:    cfg.rise_sigmas    <= pwdata[SIGMAS_W-1:0];
        REG_FALL_SIGMAS:    cfg.fall_sigmas    <= pwdata[SIGMAS_W-1:0];
        REG_THRESHOLD:      cfg.threshold      <= pwdata[LEVEL_W-1:0];
        REG_PEDESTAL_MEAN:  cfg.pedestal_mean  <= pwdata[LEVEL_W-1:0];
        REG_PEDESTAL_SIGMA: cfg.pedestal_sigma <= pwdata[SIGMA_W-1:0];
        REG_CHANNEL_ID:     cfg.channel_id     <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; addresses beyond the map read as zero.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RISE_SIGMAS:    prdata = PDATA_W'(cfg.rise_sigmas);
      REG_FALL_SIGMAS:    prdata = PDATA_W'(cfg.fall_sigmas);
      REG_THRESHOLD:      prdata = PDATA_W'(cfg.threshold);
      REG_PEDESTAL_MEAN:  prdata = PDATA_W'(cfg.pedestal_mean);
      REG_PEDESTAL_SIGMA: prdata = PDATA_W'(cfg.pedestal_sigma);
      REG_CHANNEL_ID:     prdata = PDATA_W'(cfg.channel_id);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: sv/pulse_finder_threshold.sv
// The item that closes a pulse passes the input register, then its record is loaded into the result register.
// Throughput: one sample item per cycle; the input register and the per-sample compare,
// area accumulate and peak update in front of the result register set that figure.
// A record held at the output stalls the input once the input register is also full.
// Reset (rst, synchronous) clears the sample counter, the open-pulse flag, both valid bits
// and the settings to their defaults. Depends on pft_pkg and pft_regs.
module pulse_finder_threshold (
  input  logic                               clk,
  input  logic                               rst,
  // Sample channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pft_pkg::SAMPLE_W-1:0]       sample,
  input  logic                               last,
  // Pulse record channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pft_pkg::CHAN_W-1:0]         channel,
  output logic [pft_pkg::IDX_W-1:0]          start_index,
  output logic [pft_pkg::IDX_W-1:0]          end_index,
  output logic [pft_pkg::IDX_W-1:0]          peak_index,
  output logic signed [pft_pkg::AMP_W-1:0]   amplitude,
  output logic [pft_pkg::AREA_W-1:0]         area,
  output logic [pft_pkg::LEVEL_W-1:0]        baseline,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pft_pkg::PADDR_W-1:0]        paddr,
  input  logic [pft_pkg::PDATA_W-1:0]        pwdata,
  output logic [pft_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import pft_pkg::*;

  localparam int LVL8_W = LEVEL_W + 4;   // Q.8 sigma levels
  localparam int SUM_W  = AREA_W + 1;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  cfg_t cfg;

  pft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_last;
  logic                s1_fire;
  logic                out_free;

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
      s1_last   <= last;
    end
  end

  // Pulse state.
  logic [IDX_W-1:0]    sample_index, sample_index_next;
  logic                pulse_open, pulse_open_next;
  logic [IDX_W-1:0]    open_start, open_start_next;
  logic [IDX_W-1:0]    peak_pos, peak_pos_next;
  logic [SAMPLE_W-1:0] peak_value, peak_value_next;
  logic [AREA_W-1:0]   area_sum, area_sum_next;

  // Level compares for the sample in the input register.
  logic [SAMPLE_W-1:0] s;
  logic [LEVEL_W-1:0]  s_q4;
  logic [LVL8_W:0]     s_q8;
  logic [LVL8_W:0]     ped_q8;
  logic [LVL8_W:0]     rise_lvl;
  logic [LVL8_W:0]     fall_lvl;
  logic [LEVEL_W:0]    thr_lvl;
  logic                rise_hit;
  logic                fall_hit;
  logic                thr_hit;
  logic                is_last;

  assign s        = SAMPLE_W'(s1_sample[SAMPLE_BITS-1:0]);
  assign s_q4     = {s, 4'b0000};
  assign s_q8     = {1'b0, s, 8'b0};
  assign ped_q8   = {1'b0, cfg.pedestal_mean, 4'b0000};
  assign rise_lvl = ped_q8 + (LVL8_W+1)'(cfg.rise_sigmas * cfg.pedestal_sigma);
  assign fall_lvl = ped_q8 + (LVL8_W+1)'(cfg.fall_sigmas * cfg.pedestal_sigma);
  assign thr_lvl  = {1'b0, cfg.pedestal_mean} + {1'b0, cfg.threshold};
  assign rise_hit = s_q8 > rise_lvl;
  assign fall_hit = s_q8 > fall_lvl;
  assign thr_hit  = {1'b0, s_q4} > thr_lvl;
  assign is_last  = s1_last || (sample_index == IDX_LAST);

  // Positive excess over the pedestal and the saturating area sum.
  logic               excess_pos;
  logic [LEVEL_W-1:0] excess;
  logic [SUM_W-1:0]   area_add;
  logic [AREA_W-1:0]  area_acc;

  assign excess_pos = s_q4 >= cfg.pedestal_mean;
  assign excess     = s_q4 - cfg.pedestal_mean;
  assign area_add   = {1'b0, area_sum} + SUM_W'(excess);
  assign area_acc   = area_add[AREA_W] ? AREA_MAX : area_add[AREA_W-1:0];

  // Next state and the record to emit.
  logic                    emit;
  logic [IDX_W-1:0]        rec_start;
  logic [IDX_W-1:0]        rec_peak;
  logic signed [AMP_W-1:0] rec_amp;
  logic [AREA_W-1:0]       rec_area;

  always_comb begin
    sample_index_next = sample_index;
    pulse_open_next   = pulse_open;
    open_start_next   = open_start;
    peak_pos_next     = peak_pos;
    peak_value_next   = peak_value;
    area_sum_next     = area_sum;
    emit              = 1'b0;
    rec_start         = open_start;
    rec_peak          = peak_pos;
    rec_amp           = AMP_W'({1'b0, peak_value, 4'b0000}) - AMP_W'(cfg.pedestal_mean);
    rec_area          = area_sum;

    if (s1_fire) begin
      if (pulse_open) begin
        if (is_last || (!fall_hit && !thr_hit)) begin
          // Closing sample: takes no part in peak or area.
          emit            = 1'b1;
          pulse_open_next = 1'b0;
        end else begin
          if (excess_pos) begin
            area_sum_next = area_acc;
          end
          if (s > peak_value) begin
            peak_value_next = s;
            peak_pos_next   = sample_index;
          end
        end
      end else if (rise_hit && thr_hit) begin
        // Opening sample is above the threshold, hence above the pedestal.
        open_start_next = sample_index;
        peak_value_next = s;
        peak_pos_next   = sample_index;
        if (is_last) begin
          area_sum_next = '0;
          emit          = 1'b1;
          rec_start     = sample_index;
          rec_peak      = sample_index;
          rec_amp       = AMP_W'({1'b0, s_q4}) - AMP_W'(cfg.pedestal_mean);
          rec_area      = '0;
        end else begin
          area_sum_next   = AREA_W'(excess);
          pulse_open_next = 1'b1;
        end
      end

      // Waveform boundary.
      if (is_last) begin
        sample_index_next = '0;
        pulse_open_next   = 1'b0;
      end else begin
        sample_index_next = sample_index + 1'b1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      pulse_open   <= 1'b0;
      open_start   <= '0;
      peak_pos     <= '0;
      peak_value   <= '0;
      area_sum     <= '0;
    end else begin
      sample_index <= sample_index_next;
      pulse_open   <= pulse_open_next;
      open_start   <= open_start_next;
      peak_pos     <= peak_pos_next;
      peak_value   <= peak_value_next;
      area_sum     <= area_sum_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      channel     <= cfg.channel_id;
      start_index <= rec_start;
      end_index   <= sample_index;
      peak_index  <= rec_peak;
      amplitude   <= rec_amp;
      area        <= rec_area;
      baseline    <= cfg.pedestal_mean;
    end
  end

`ifndef NO_ASSERTIONS
  // A record never ends before it starts.
  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_index >= start_index)
    else $error("pulse record ends before its start");

  // The peak lies inside the pulse.
  a_peak_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_index >= start_index) && (peak_index <= end_index))
    else $error("peak index outside the pulse");

  // A pulse that opens and closes on one sample has no area.
  a_single_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && (start_index == end_index) |-> area == '0)
    else $error("one-sample pulse with nonzero area");

  // The end of a waveform restarts the sample count and closes any pulse.
  a_wave_end: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> (sample_index == '0) && !pulse_open)
    else $error("state not cleared at end of waveform");

  // An open pulse keeps its peak at or after its start.
  a_open_peak: assert property (@(posedge clk) disable iff (rst)
    pulse_open |-> peak_pos >= open_start)
    else $error("open pulse peak before start");
`endif

endmodule

// File: test/testbench.sv
// Testbench for the threshold pulse finder: sends waveforms of ADC samples,
// predicts each pulse record in its own model and checks every record field.
// Depends on pft_pkg and pulse_finder_threshold.
`timescale 1ns / 1ps

module testbench;
  import pft_pkg::*;

  localparam logic [31:0] AREA_FULL  = (32'd1 << AREA_W) - 32'd1;
  localparam int          SAMPLE_TOP = (1 << SAMPLE_W) - 1;
  localparam int          SETTLE     = 8;

  // One pulse record as it leaves the block.
  typedef struct {
    logic [CHAN_W-1:0]       channel;
    logic [IDX_W-1:0]        start_index;
    logic [IDX_W-1:0]        end_index;
    logic [IDX_W-1:0]        peak_index;
    logic signed [AMP_W-1:0] amplitude;
    logic [AREA_W-1:0]       area;
    logic [LEVEL_W-1:0]      baseline;
  } pulse_rec_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [SAMPLE_W-1:0]       sample;
  logic                      last;
  logic                      out_valid;
  logic                      out_ready;
  logic [CHAN_W-1:0]         channel;
  logic [IDX_W-1:0]          start_index;
  logic [IDX_W-1:0]          end_index;
  logic [IDX_W-1:0]          peak_index;
  logic signed [AMP_W-1:0]   amplitude;
  logic [AREA_W-1:0]         area;
  logic [LEVEL_W-1:0]        baseline;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // Settings as the finder sees them, and its waveform state.
  cfg_t                      cfg;
  logic [IDX_W-1:0]          wave_index;
  bit                        in_pulse;
  logic [IDX_W-1:0]          pulse_start;
  logic [IDX_W-1:0]          pulse_peak_pos;
  logic [SAMPLE_W-1:0]       pulse_peak;
  logic [AREA_W-1:0]         pulse_area;

  pulse_rec_t                pending_pulses[$];
  logic [SAMPLE_W-1:0]       wave_buf[$];
  int                        error_count;
  int                        samples_sent;
  int                        hold_left;
  bit                        gaps_on;
  bit                        stalls_on;

  pulse_finder_threshold dut (.*);

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Pulse finder prediction
  // ---------------------------------------------------------------------------

  // Sample above a sigma level, compared in Q.8.
  function automatic bit over_sigma(logic [SAMPLE_W-1:0] s, logic [SIGMAS_W-1:0] nsig);
    logic [31:0] lhs;
    logic [31:0] rhs;
    lhs = 32'(s) << 8;
    rhs = (32'(cfg.pedestal_mean) << 4) + 32'(nsig) * 32'(cfg.pedestal_sigma);
    return lhs > rhs;
  endfunction

  // Sample above the absolute threshold, compared in Q.4.
  function automatic bit over_threshold(logic [SAMPLE_W-1:0] s);
    return (32'(s) << 4) > 32'(cfg.pedestal_mean) + 32'(cfg.threshold);
  endfunction

  // Add one sample to the open pulse: saturating area and first maximum.
  function automatic void add_to_pulse(logic [SAMPLE_W-1:0] s, logic [IDX_W-1:0] idx);
    logic [31:0] s4;
    logic [31:0] sum;
    s4 = 32'(s) << 4;
    if (s4 >= 32'(cfg.pedestal_mean)) begin
      sum = 32'(pulse_area) + s4 - 32'(cfg.pedestal_mean);
      pulse_area = (sum > AREA_FULL) ? AREA_FULL[AREA_W-1:0] : sum[AREA_W-1:0];
    end
    if (s > pulse_peak) begin
      pulse_peak = s;
      pulse_peak_pos = idx;
    end
  endfunction

  function automatic void close_pulse(logic [IDX_W-1:0] idx);
    pulse_rec_t  rec;
    logic [31:0] amp;
    amp = (32'(pulse_peak) << 4) - 32'(cfg.pedestal_mean);
    rec.channel     = cfg.channel_id;
    rec.start_index = pulse_start;
    rec.end_index   = idx;
    rec.peak_index  = pulse_peak_pos;
    rec.amplitude   = amp[AMP_W-1:0];
    rec.area        = pulse_area;
    rec.baseline    = cfg.pedestal_mean;
    pending_pulses.insert(pending_pulses.size(), rec);
  endfunction

  // Advance the finder by one accepted sample item.
  function automatic void predict_sample(logic [SAMPLE_W-1:0] s, logic l);
    logic [IDX_W-1:0] idx;
    bit               ends;
    idx  = wave_index;
    ends = l || (int'(idx) >= MAX_SAMPLES - 1);
    if (in_pulse) begin
      if (ends || (!over_sigma(s, cfg.fall_sigmas) && !over_threshold(s))) begin
        close_pulse(idx);
        in_pulse = 0;
      end else begin
        add_to_pulse(s, idx);
      end
    end else if (over_sigma(s, cfg.rise_sigmas) && over_threshold(s)) begin
      pulse_start    = idx;
      pulse_peak     = s;
      pulse_peak_pos = idx;
      pulse_area     = '0;
      if (ends) begin
        // A pulse opening on the last sample ends and peaks right there.
        close_pulse(idx);
      end else begin
        pulse_peak = '0;
        add_to_pulse(s, idx);
        in_pulse = 1;
      end
    end
    if (ends) begin
      wave_index = '0;
      in_pulse   = 0;
    end else begin
      wave_index = idx + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Record checker and receiver
  // ---------------------------------------------------------------------------

  // Compare every accepted record with the oldest predicted one.
  always @(posedge clk) begin
    pulse_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pulses.size() == 0) begin
        report_mismatch("record with none expected, start_index", start_index, 0);
      end else begin
        want = pending_pulses.pop_front();
        if (channel !== want.channel)
          report_mismatch("channel", channel, want.channel);
        if (start_index !== want.start_index)
          report_mismatch("start_index", start_index, want.start_index);
        if (end_index !== want.end_index)
          report_mismatch("end_index", end_index, want.end_index);
        if (peak_index !== want.peak_index)
          report_mismatch("peak_index", peak_index, want.peak_index);
        if (amplitude !== want.amplitude)
          report_mismatch("amplitude", amplitude, want.amplitude);
        if (area !== want.area)
          report_mismatch("area", area, want.area);
        if (baseline !== want.baseline)
          report_mismatch("baseline", baseline, want.baseline);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left counts down.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stalls_on) begin
        out_ready <= ($urandom_range(99) >= 26);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender, configuration and waveform builders
  // ---------------------------------------------------------------------------

  // Offer one sample item and hold it until the block takes it.
  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic l);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    predict_sample(s, l);
    samples_sent++;
  endtask

  // Send wave_buf as one waveform, last set on its final sample.
  task automatic send_wave();
    foreach (wave_buf[i]) send_sample(wave_buf[i], i == wave_buf.size() - 1);
  endtask

  // Stop sending and wait until every predicted record has arrived.
  task automatic wait_for_records();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_t r, logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_RISE_SIGMAS:    cfg.rise_sigmas    = v[SIGMAS_W-1:0];
      REG_FALL_SIGMAS:    cfg.fall_sigmas    = v[SIGMAS_W-1:0];
      REG_THRESHOLD:      cfg.threshold      = v[LEVEL_W-1:0];
      REG_PEDESTAL_MEAN:  cfg.pedestal_mean  = v[LEVEL_W-1:0];
      REG_PEDESTAL_SIGMA: cfg.pedestal_sigma = v[SIGMA_W-1:0];
      REG_CHANNEL_ID:     cfg.channel_id     = v[CHAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reprogram all settings once the block has gone quiet.
  task automatic set_config(int rise, int fall, int thr, int mean, int sigma, int chan);
    wait_for_records();
    write_reg(REG_RISE_SIGMAS, rise);
    write_reg(REG_FALL_SIGMAS, fall);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_PEDESTAL_MEAN, mean);
    write_reg(REG_PEDESTAL_SIGMA, sigma);
    write_reg(REG_CHANNEL_ID, chan);
  endtask

  function automatic logic [SAMPLE_W-1:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_TOP) return SAMPLE_W'(SAMPLE_TOP);
    return v[SAMPLE_W-1:0];
  endfunction

  // Append one sample to the waveform being built.
  function automatic void append_sample(logic [SAMPLE_W-1:0] v);
    wave_buf.insert(wave_buf.size(), v);
  endfunction

  // Zero or full scale now and then, otherwise anything in range.
  function automatic int pick_level(int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 0;
    if (roll < 30) return hi;
    return $urandom_range(hi);
  endfunction

  // Noisy baseline with triangular pulses of random width and height.
  function automatic void make_shaped_wave(int base, int len);
    int spread;
    int w;
    int h;
    int j;
    spread = $urandom_range(6);
    wave_buf.delete();
    while (wave_buf.size() < len) begin
      if ($urandom_range(99) < 15) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, SAMPLE_TOP);
        for (j = 0; j < w && wave_buf.size() < len; j++)
          append_sample(clip_sample(base + h * (w - j) / w +
                                    int'($urandom_range(2 * spread)) - spread));
      end else begin
        append_sample(clip_sample(base + int'($urandom_range(2 * spread)) - spread));
      end
    end
  endfunction

  // Unstructured samples, full scale or zero now and then.
  function automatic void make_noise_wave(int len);
    int roll;
    wave_buf.delete();
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < 12) append_sample('0);
      else if (roll < 24) append_sample(SAMPLE_W'(SAMPLE_TOP));
      else append_sample(SAMPLE_W'($urandom_range(SAMPLE_TOP)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default settings: a pulse closed by the fall level, one opening on the last
  // sample, one closed by the last sample, and a waveform with no pulse.
  task automatic test_directed();
    wave_buf = '{0, 20, 4095, 4095, 30, 1, 0};
    send_wave();
    wave_buf = '{4095};
    send_wave();
    wave_buf = '{0, 50, 60, 40};
    send_wave();
    wave_buf = '{11, 10, 11};
    send_wave();
    wave_buf = '{1};
    send_wave();
    wave_buf = '{12, 2, 3, 1, 0, 4095};
    send_wave();
  endtask

  // All settings but the channel at zero, then at full scale; the channel takes the other extreme.
  task automatic test_config_extremes();
    set_config(0, 0, 0, 0, 0, (1 << CHAN_W) - 1);
    wave_buf = '{0, 1, 4095, 2, 0, 5, 4095};
    send_wave();
    wave_buf = '{4095};
    send_wave();
    set_config((1 << SIGMAS_W) - 1, (1 << SIGMAS_W) - 1, (1 << LEVEL_W) - 1,
               (1 << LEVEL_W) - 1, (1 << SIGMA_W) - 1, 0);
    wave_buf = '{4095, 0, 4095};
    send_wave();
  endtask

  // Receiver holds off while short pulses keep coming, so the block must stall
  // its input; then the sender pauses until every record is out.
  task automatic test_backpressure();
    set_config(RISE_SIGMAS_RST, FALL_SIGMAS_RST, THRESHOLD_RST, PEDESTAL_MEAN_RST,
               PEDESTAL_SIGMA_RST, 77);
    hold_left = 300;
    wave_buf.delete();
    repeat (100) begin
      append_sample(SAMPLE_W'(20));
      append_sample('0);
    end
    send_wave();
    wait_for_records();
  endtask

  // Phases of random settings, mostly realistic waveforms, some noise.
  task automatic test_random();
    int phase;
    int target;
    int budget;
    int base;
    int mean;
    int thr;
    int sigma;
    phase  = 0;
    target = 1600;
    while (samples_sent < target) begin
      // The first phases run with no idling on either side.
      gaps_on   = (phase >= 2);
      stalls_on = (phase >= 2);
      base = $urandom_range(3000);
      mean = base * 16 + $urandom_range(15);
      if ($urandom_range(99) < 10) begin
        mean = pick_level((1 << LEVEL_W) - 1);
        base = mean >> 4;
      end
      thr   = ($urandom_range(99) < 10) ? pick_level((1 << LEVEL_W) - 1)
                                        : $urandom_range(1600);
      sigma = ($urandom_range(99) < 10) ? pick_level((1 << SIGMA_W) - 1)
                                        : $urandom_range(80);
      set_config(pick_level((1 << SIGMAS_W) - 1), pick_level((1 << SIGMAS_W) - 1),
                 thr, mean, sigma, pick_level((1 << CHAN_W) - 1));
      budget = samples_sent + $urandom_range(60, 140);
      while (samples_sent < budget) begin
        if ($urandom_range(99) < 15) make_noise_wave($urandom_range(1, 40));
        else make_shaped_wave(base, $urandom_range(2, 60));
        send_wave();
      end
      phase++;
    end
    gaps_on   = 1;
    stalls_on = 1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample    <= '0;
    last      <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    gaps_on      = 1;
    stalls_on    = 1;
    hold_left    = 0;
    error_count  = 0;
    samples_sent = 0;
    cfg.rise_sigmas    = RISE_SIGMAS_RST;
    cfg.fall_sigmas    = FALL_SIGMAS_RST;
    cfg.threshold      = THRESHOLD_RST;
    cfg.pedestal_mean  = PEDESTAL_MEAN_RST;
    cfg.pedestal_sigma = PEDESTAL_SIGMA_RST;
    cfg.channel_id     = CHANNEL_ID_RST;
    wave_index     = '0;
    in_pulse       = 0;
    pulse_start    = '0;
    pulse_peak_pos = '0;
    pulse_peak     = '0;
    pulse_area     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();

    wait_for_records();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
